FILE: src/lsm_pkg.sv
// Shared types, constants and state encodings of the line segment merger.
// Depends on nothing; every other file imports it.
`default_nettype none
package lsm_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ICPT_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFF     = 3'd4;

    localparam logic signed [23:0] SLOPE_MIN = 24'sh800000;

    typedef struct packed {
        logic [9:0] seg_x_a;
        logic [9:0] seg_y_a;
        logic [9:0] seg_x_b;
        logic [9:0] seg_y_b;
        logic       last_segment;
    } in_item_t;

    typedef struct packed {
        logic [9:0]         out_x_low;
        logic [9:0]         out_y_low;
        logic [9:0]         out_x_high;
        logic [9:0]         out_y_high;
        logic signed [23:0] out_slope;
        logic signed [31:0] out_intercept;
        logic               run_last;
        logic               overflow_seen;
    } out_item_t;

    typedef struct packed {
        logic [9:0] xl;
        logic [9:0] yl;
        logic [9:0] xh;
        logic [9:0] yh;
    } pts_t;

    typedef struct packed {
        pts_t               pts;
        logic signed [23:0] slope;
        logic signed [31:0] icpt;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic merge;
        pts_t pts;
    } pair_res_t;

    typedef enum logic [4:0] {
        S_LOAD, S_LFIT,
        S_SORT_I, S_SORT_IW, S_SORT_JR, S_SORT_JW, S_SORT_WB,
        S_MRG_I, S_MRG_IW, S_MRG_J, S_MRG_JW, S_MRG_PAIR, S_MRG_FIT, S_MRG_WB,
        S_CMP_R, S_CMP_W,
        S_OUT_R, S_OUT_W, S_OUT_H
    } lsm_state_t;

    typedef enum logic [2:0] {
        FIT_IDLE, FIT_DIV, FIT_MUL, FIT_SUB, FIT_DONE
    } fit_state_t;

endpackage
`default_nettype wire

FILE: src/line_segment_merger.sv
// Top level of the line segment merger: configuration, entry memory and the
// load, sort, merge and emit sequencer. Depends on lsm_pkg, lsm_fit, lsm_pair.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------
//   in       | input     | in_valid / in_stall  | in_data  (in_item_t)
//   out      | output    | out_valid / out_stall| out_data (out_item_t)
//   cfg      | input     | cfg_write            | cfg_index, cfg_data
//
// A stored segment passes through the 18-step slope divider unless it is
// vertical. After the last segment come the exchange sort and the merge rounds,
// all on the entry memory with its one read port and one write port. Each result
// is read, registered and then held until the output takes it. Reset clears the
// counters and the absorbed marks and returns the configuration to its
// defaults.
`default_nettype none
module line_segment_merger (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire lsm_pkg::in_item_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output lsm_pkg::out_item_t                       out_data,
    input  wire logic                                cfg_write,
    input  wire logic [lsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lsm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lsm_pkg::*;

    logic [15:0] slope_thr_reg, icpt_thr_reg;
    logic [21:0] dist_thr_reg;
    logic [9:0]  x_off_reg, y_off_reg;

    lsm_state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, i_reg, j_reg, k_reg;
    logic        ovf_reg, round_reg, last_pend_reg;
    logic [MAX_SEGMENTS-1:0] absorbed_reg;

    entry_t      mem [MAX_SEGMENTS];
    entry_t      rd_data_reg, cur_reg, wr_data;
    logic        rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    pts_t        ld_pts_reg, orient, fit_pts;
    out_item_t   out_reg;

    logic        fit_start, fit_done, pair_start, in_acc, out_acc;
    logic signed [23:0] fit_slope;
    logic signed [31:0] fit_icpt;
    pair_res_t   pair_res;

    logic [9:0]  xa, ya, xb, yb;
    logic [10:0] sx_a, sy_a, sx_b, sy_b;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        if (in_data.seg_y_a < in_data.seg_y_b)
        begin
            xa = in_data.seg_x_b; ya = in_data.seg_y_b;
            xb = in_data.seg_x_a; yb = in_data.seg_y_a;
        end
        else
        begin
            xa = in_data.seg_x_a; ya = in_data.seg_y_a;
            xb = in_data.seg_x_b; yb = in_data.seg_y_b;
        end
        sx_a = {1'b0, xa} + {1'b0, x_off_reg};
        sy_a = {1'b0, ya} + {1'b0, y_off_reg};
        sx_b = {1'b0, xb} + {1'b0, x_off_reg};
        sy_b = {1'b0, yb} + {1'b0, y_off_reg};
        orient.xl = sx_a[10] ? 10'd1023 : sx_a[9:0];
        orient.yl = sy_a[10] ? 10'd1023 : sy_a[9:0];
        orient.xh = sx_b[10] ? 10'd1023 : sx_b[9:0];
        orient.yh = sy_b[10] ? 10'd1023 : sy_b[9:0];
    end

    assign fit_pts = (state_reg == S_LOAD) ? orient : pair_res.pts;

    lsm_fit u_fit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fit_start),
        .pts   (fit_pts),
        .done  (fit_done),
        .slope (fit_slope),
        .icpt  (fit_icpt)
    );

    lsm_pair u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pair_start),
        .a         (cur_reg),
        .b         (rd_data_reg),
        .slope_thr (slope_thr_reg),
        .icpt_thr  (icpt_thr_reg),
        .dist_thr  (dist_thr_reg),
        .res       (pair_res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg < CNT_W'(MAX_SEGMENTS)) state_next = S_LFIT;
                    else if (in_data.last_segment)       state_next = S_SORT_I;
                end
            end
            S_LFIT:    if (fit_done) state_next = last_pend_reg ? S_SORT_I : S_LOAD;
            S_SORT_I:  state_next = (i_reg + 1'b1 >= count_reg) ? S_MRG_I : S_SORT_IW;
            S_SORT_IW: state_next = S_SORT_JR;
            S_SORT_JR: state_next = S_SORT_JW;
            S_SORT_JW: state_next = (j_reg + 1'b1 == count_reg) ? S_SORT_WB : S_SORT_JR;
            S_SORT_WB: state_next = S_SORT_I;
            S_MRG_I:
            begin
                if (i_reg + 1'b1 >= count_reg)          state_next = S_CMP_R;
                else if (!absorbed_reg[i_reg[IDX_W-1:0]]) state_next = S_MRG_IW;
            end
            S_MRG_IW:  state_next = S_MRG_J;
            S_MRG_J:
            begin
                if (j_reg >= count_reg)                   state_next = S_MRG_WB;
                else if (!absorbed_reg[j_reg[IDX_W-1:0]]) state_next = S_MRG_JW;
            end
            S_MRG_JW:  state_next = S_MRG_PAIR;
            S_MRG_PAIR:
            begin
                if (pair_res.valid) state_next = pair_res.merge ? S_MRG_FIT : S_MRG_J;
            end
            S_MRG_FIT: if (fit_done) state_next = S_MRG_J;
            S_MRG_WB:  state_next = S_MRG_I;
            S_CMP_R:
            begin
                if (i_reg >= count_reg)                   state_next = round_reg ? S_OUT_R
                                                                                 : S_MRG_I;
                else if (!absorbed_reg[i_reg[IDX_W-1:0]]) state_next = S_CMP_W;
            end
            S_CMP_W:   state_next = S_CMP_R;
            S_OUT_R:   state_next = S_OUT_W;
            S_OUT_W:   state_next = S_OUT_H;
            S_OUT_H:
            begin
                if (out_acc) state_next = out_reg.run_last ? S_LOAD : S_OUT_R;
            end
            default:   state_next = S_LOAD;
        endcase
    end

    // Memory port and unit controls.
    always_comb
    begin
        in_stall   = (state_reg != S_LOAD);
        out_valid  = (state_reg == S_OUT_H);
        fit_start  = 1'b0;
        pair_start = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = i_reg[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = i_reg[IDX_W-1:0];
        wr_data    = cur_reg;
        unique case (state_reg)
            S_LOAD:    fit_start = in_valid && (count_reg < CNT_W'(MAX_SEGMENTS));
            S_LFIT:
            begin
                wr_en   = fit_done;
                wr_addr = count_reg[IDX_W-1:0];
                wr_data = '{pts: ld_pts_reg, slope: fit_slope, icpt: fit_icpt};
            end
            S_SORT_I:  rd_en = (i_reg + 1'b1 < count_reg);
            S_SORT_JR:
            begin
                rd_en   = 1'b1;
                rd_addr = j_reg[IDX_W-1:0];
            end
            S_SORT_JW:
            begin
                wr_en   = (cur_reg.slope > rd_data_reg.slope);
                wr_addr = j_reg[IDX_W-1:0];
            end
            S_SORT_WB: wr_en = 1'b1;
            S_MRG_I:   rd_en = (i_reg + 1'b1 < count_reg) && !absorbed_reg[i_reg[IDX_W-1:0]];
            S_MRG_J:
            begin
                rd_en   = (j_reg < count_reg) && !absorbed_reg[j_reg[IDX_W-1:0]];
                rd_addr = j_reg[IDX_W-1:0];
            end
            S_MRG_JW:  pair_start = 1'b1;
            S_MRG_PAIR: fit_start = pair_res.valid && pair_res.merge;
            S_MRG_WB:  wr_en = 1'b1;
            S_CMP_R:   rd_en = (i_reg < count_reg) && !absorbed_reg[i_reg[IDX_W-1:0]];
            S_CMP_W:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg[IDX_W-1:0];
                wr_data = rd_data_reg;
            end
            S_OUT_R:   rd_en = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_thr_reg <= 16'd51;
            icpt_thr_reg  <= 16'd160;
            dist_thr_reg  <= 22'd5000;
            x_off_reg     <= 10'd10;
            y_off_reg     <= 10'd200;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SLOPE_THR: slope_thr_reg <= cfg_data[15:0];
                CFG_ICPT_THR:  icpt_thr_reg  <= cfg_data[15:0];
                CFG_DIST_THR:  dist_thr_reg  <= cfg_data;
                CFG_X_OFF:     x_off_reg     <= cfg_data[9:0];
                CFG_Y_OFF:     y_off_reg     <= cfg_data[9:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            round_reg     <= 1'b0;
            last_pend_reg <= 1'b0;
            absorbed_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_LOAD:
                begin
                    i_reg <= '0;
                    if (in_acc)
                    begin
                        last_pend_reg <= in_data.last_segment;
                        if (count_reg >= CNT_W'(MAX_SEGMENTS)) ovf_reg <= 1'b1;
                    end
                end
                S_LFIT:    if (fit_done) count_reg <= count_reg + 1'b1;
                S_SORT_I:  if (i_reg + 1'b1 >= count_reg) i_reg <= '0;
                S_SORT_IW: j_reg <= i_reg + 1'b1;
                S_SORT_JW: j_reg <= j_reg + 1'b1;
                S_SORT_WB: i_reg <= i_reg + 1'b1;
                S_MRG_I:
                begin
                    if (i_reg + 1'b1 >= count_reg)
                    begin
                        i_reg <= '0;
                        k_reg <= '0;
                    end
                    else if (absorbed_reg[i_reg[IDX_W-1:0]])
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_MRG_IW:  j_reg <= i_reg + 1'b1;
                S_MRG_J:
                begin
                    if (j_reg < count_reg && absorbed_reg[j_reg[IDX_W-1:0]])
                        j_reg <= j_reg + 1'b1;
                end
                S_MRG_PAIR:
                begin
                    if (pair_res.valid)
                    begin
                        if (pair_res.merge) absorbed_reg[j_reg[IDX_W-1:0]] <= 1'b1;
                        else                j_reg <= j_reg + 1'b1;
                    end
                end
                S_MRG_FIT: if (fit_done) j_reg <= j_reg + 1'b1;
                S_MRG_WB:  i_reg <= i_reg + 1'b1;
                S_CMP_R:
                begin
                    if (i_reg >= count_reg)
                    begin
                        count_reg    <= k_reg;
                        absorbed_reg <= '0;
                        i_reg        <= '0;
                        round_reg    <= !round_reg;
                    end
                    else if (absorbed_reg[i_reg[IDX_W-1:0]])
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_CMP_W:
                begin
                    k_reg <= k_reg + 1'b1;
                    i_reg <= i_reg + 1'b1;
                end
                S_OUT_H:
                begin
                    if (out_acc)
                    begin
                        i_reg <= i_reg + 1'b1;
                        if (out_reg.run_last)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers: the entry under work and the pending result.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_LOAD:    if (in_acc) ld_pts_reg <= orient;
            S_SORT_IW: cur_reg <= rd_data_reg;
            S_SORT_JW: if (cur_reg.slope > rd_data_reg.slope) cur_reg <= rd_data_reg;
            S_MRG_IW:  cur_reg <= rd_data_reg;
            S_MRG_PAIR: if (pair_res.valid && pair_res.merge) cur_reg.pts <= pair_res.pts;
            S_MRG_FIT:
            begin
                if (fit_done)
                begin
                    cur_reg.slope <= fit_slope;
                    cur_reg.icpt  <= fit_icpt;
                end
            end
            S_OUT_W:
            begin
                out_reg.out_x_low     <= rd_data_reg.pts.xl;
                out_reg.out_y_low     <= rd_data_reg.pts.yl;
                out_reg.out_x_high    <= rd_data_reg.pts.xh;
                out_reg.out_y_high    <= rd_data_reg.pts.yh;
                out_reg.out_slope     <= rd_data_reg.slope;
                out_reg.out_intercept <= rd_data_reg.icpt;
                out_reg.run_last      <= (i_reg + 1'b1 == count_reg);
                out_reg.overflow_seen <= ovf_reg;
            end
            default: ;
        endcase
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

FILE: src/lsm_fit.sv
// Line fit of one segment: slope by a shift-subtract divider, then intercept.
// Depends on lsm_pkg.
`default_nettype none
module lsm_fit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire lsm_pkg::pts_t             pts,
    output logic                           done,
    output logic signed [23:0]             slope,
    output logic signed [31:0]             icpt
);
    import lsm_pkg::*;

    localparam int DIV_STEPS = 18;

    fit_state_t         state_reg, state_next;
    logic [4:0]         cnt_reg;
    logic [17:0]        num_reg, num_next;
    logic [9:0]         den_reg, rem_reg, rem_next;
    logic               neg_reg;
    logic [9:0]         xl_reg, yl_reg;
    logic signed [23:0] slope_reg;
    logic signed [34:0] prod_reg;
    logic signed [31:0] icpt_reg;

    logic signed [10:0] dx, dy;
    logic [10:0]        adx, ady, rem_sh;
    logic               ge;
    logic [23:0]        q_ext;
    logic signed [35:0] q8;

    assign dx = $signed({1'b0, pts.xh}) - $signed({1'b0, pts.xl});
    assign dy = $signed({1'b0, pts.yh}) - $signed({1'b0, pts.yl});
    assign adx = dx[10] ? 11'(-dx) : 11'(dx);
    assign ady = dy[10] ? 11'(-dy) : 11'(dy);

    assign rem_sh   = {rem_reg, num_reg[17]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_next = ge ? 10'(rem_sh - {1'b0, den_reg}) : rem_sh[9:0];
    assign num_next = {num_reg[16:0], ge};
    assign q_ext    = {6'b0, num_next};

    // Floor division by 16 is an arithmetic shift; the value always fits 32 bits.
    assign q8 = $signed({18'b0, yl_reg, 8'b0}) - {prod_reg[34], prod_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FIT_IDLE: if (start) state_next = (dx == 11'sd0) ? FIT_MUL : FIT_DIV;
            FIT_DIV:  if (cnt_reg == 5'(DIV_STEPS - 1)) state_next = FIT_MUL;
            FIT_MUL:  state_next = FIT_SUB;
            FIT_SUB:  state_next = FIT_DONE;
            FIT_DONE: state_next = FIT_IDLE;
            default:  state_next = FIT_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == FIT_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FIT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            FIT_IDLE:
            begin
                if (start)
                begin
                    xl_reg    <= pts.xl;
                    yl_reg    <= pts.yl;
                    num_reg   <= {ady[9:0], 8'b0};
                    den_reg   <= adx[9:0];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    neg_reg   <= dx[10] ^ dy[10];
                    slope_reg <= SLOPE_MIN;
                end
            end
            FIT_DIV:
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    slope_reg <= neg_reg ? $signed(-q_ext) : $signed(q_ext);
                end
            end
            FIT_MUL:  prod_reg <= slope_reg * $signed({1'b0, xl_reg});
            FIT_SUB:  icpt_reg <= q8[35:4];
            FIT_DONE: ;
            default:  ;
        endcase
    end

    assign slope = slope_reg;
    assign icpt  = icpt_reg;

endmodule
`default_nettype wire

FILE: src/lsm_pair.sv
// Two-stage merge test of a segment pair: distances and line checks, then the
// distance threshold and the farthest endpoint pair. Depends on lsm_pkg.
`default_nettype none
module lsm_pair (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire lsm_pkg::entry_t      a,
    input  wire lsm_pkg::entry_t      b,
    input  wire logic [15:0]          slope_thr,
    input  wire logic [15:0]          icpt_thr,
    input  wire logic [21:0]          dist_thr,
    output lsm_pkg::pair_res_t        res
);
    import lsm_pkg::*;

    localparam int PA [6] = '{0, 0, 1, 1, 0, 2};
    localparam int PB [6] = '{2, 3, 2, 3, 1, 3};

    logic [9:0]  px [4];
    logic [9:0]  py [4];
    logic [20:0] d [6];
    logic [24:0] sdiff, smag;
    logic [32:0] bdiff, bmag;

    logic        v1_reg, v2_reg;
    logic        ok_reg, merge_reg;
    logic [20:0] d_reg [6];
    logic [9:0]  px_reg [4];
    logic [9:0]  py_reg [4];
    pts_t        pts_reg;

    logic [20:0] mn, mx;
    logic [2:0]  w;
    logic [1:0]  f, s;
    pts_t        pts_new;

    always_comb
    begin
        logic [9:0]  ax, ay;
        logic [19:0] sqx, sqy;
        px[0] = a.pts.xl; py[0] = a.pts.yl;
        px[1] = a.pts.xh; py[1] = a.pts.yh;
        px[2] = b.pts.xl; py[2] = b.pts.yl;
        px[3] = b.pts.xh; py[3] = b.pts.yh;
        for (int k = 0; k < 6; k++)
        begin
            ax = (px[PA[k]] > px[PB[k]]) ? px[PA[k]] - px[PB[k]] : px[PB[k]] - px[PA[k]];
            ay = (py[PA[k]] > py[PB[k]]) ? py[PA[k]] - py[PB[k]] : py[PB[k]] - py[PA[k]];
            sqx  = {10'b0, ax} * {10'b0, ax};
            sqy  = {10'b0, ay} * {10'b0, ay};
            d[k] = {1'b0, sqx} + {1'b0, sqy};
        end
        sdiff = {a.slope[23], a.slope} - {b.slope[23], b.slope};
        smag  = sdiff[24] ? -sdiff : sdiff;
        bdiff = {a.icpt[31], a.icpt} - {b.icpt[31], b.icpt};
        bmag  = bdiff[32] ? -bdiff : bdiff;
    end

    always_comb
    begin
        mn = d_reg[0];
        for (int k = 1; k < 4; k++)
        begin
            if (d_reg[k] < mn) mn = d_reg[k];
        end
        mx = d_reg[0];
        w  = 3'd0;
        for (int k = 1; k < 6; k++)
        begin
            if (d_reg[k] > mx)
            begin
                mx = d_reg[k];
                w  = 3'(k);
            end
        end
        f = 2'(PA[0]);
        s = 2'(PB[0]);
        for (int k = 1; k < 6; k++)
        begin
            if (w == 3'(k))
            begin
                f = 2'(PA[k]);
                s = 2'(PB[k]);
            end
        end
        // The first point of the pair becomes the low end only if its y is larger.
        if (py_reg[f] > py_reg[s])
        begin
            pts_new = '{xl: px_reg[f], yl: py_reg[f], xh: px_reg[s], yh: py_reg[s]};
        end
        else
        begin
            pts_new = '{xl: px_reg[s], yl: py_reg[s], xh: px_reg[f], yh: py_reg[f]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg  <= d;
            px_reg <= px;
            py_reg <= py;
            ok_reg <= (smag < {9'b0, slope_thr}) && (bmag < {17'b0, icpt_thr});
        end
        if (v1_reg)
        begin
            merge_reg <= ok_reg && ({1'b0, mn} < dist_thr);
            pts_reg   <= pts_new;
        end
    end

    assign res = '{valid: v2_reg, merge: merge_reg, pts: pts_reg};

endmodule
`default_nettype wire

FILE: tb/line_segment_merger_test.sv
// Self-checking testbench for the line segment merger: a built-in predictor,
// random idling on both channels and configuration sweeps. Depends on lsm_pkg.
`default_nettype none
module line_segment_merger_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lsm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SLOPE_THR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    line_segment_merger dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state.
    longint slope_thr, icpt_thr, dist_thr, x_off, y_off;
    pts_t seg_pts[MAX_SEGMENTS];
    longint seg_slope[MAX_SEGMENTS];
    longint seg_icpt[MAX_SEGMENTS];
    bit absorbed[MAX_SEGMENTS];
    int seg_count;
    bit dropped_any;

    out_item_t expected_segments[$];
    int mismatches;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;

    function automatic logic [9:0] add_offset(longint v, longint off);
        longint s;
        s = v + off;
        return (s > 1023) ? 10'd1023 : s[9:0];
    endfunction

    function automatic void fit_line(int i);
        longint dy, dx, m, q8, b;
        dy = longint'(seg_pts[i].yh) - longint'(seg_pts[i].yl);
        dx = longint'(seg_pts[i].xh) - longint'(seg_pts[i].xl);
        if (dx == 0)
            m = -8388608;
        else
        begin
            m = (dy * 256) / dx;
            if (m < -8388608) m = -8388608;
            if (m > 8388607) m = 8388607;
        end
        q8 = longint'(seg_pts[i].yl) * 256 - m * longint'(seg_pts[i].xl);
        if (q8 < 0)
            b = -((-q8 + 15) / 16);
        else
            b = q8 / 16;
        if (b < -64'sd2147483648) b = -64'sd2147483648;
        if (b > 64'sd2147483647) b = 64'sd2147483647;
        seg_slope[i] = m;
        seg_icpt[i] = b;
    endfunction

    function automatic longint abs_diff(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic bit try_join(int i, int j);
        int pa[6] = '{0, 0, 1, 1, 0, 2};
        int pb[6] = '{2, 3, 2, 3, 1, 3};
        longint px[4], py[4], d[6], mn, mx;
        int w, f, s, t;
        px[0] = seg_pts[i].xl; py[0] = seg_pts[i].yl;
        px[1] = seg_pts[i].xh; py[1] = seg_pts[i].yh;
        px[2] = seg_pts[j].xl; py[2] = seg_pts[j].yl;
        px[3] = seg_pts[j].xh; py[3] = seg_pts[j].yh;
        for (int k = 0; k < 6; k++)
            d[k] = (px[pa[k]] - px[pb[k]]) * (px[pa[k]] - px[pb[k]])
                 + (py[pa[k]] - py[pb[k]]) * (py[pa[k]] - py[pb[k]]);
        mn = d[0];
        for (int k = 1; k < 4; k++)
            if (d[k] < mn) mn = d[k];
        if (!(abs_diff(seg_slope[i], seg_slope[j]) < slope_thr)) return 0;
        if (!(abs_diff(seg_icpt[i], seg_icpt[j]) < icpt_thr)) return 0;
        if (!(mn < dist_thr)) return 0;
        mx = d[0];
        w = 0;
        for (int k = 1; k < 6; k++)
            if (d[k] > mx)
            begin
                mx = d[k];
                w = k;
            end
        f = pa[w];
        s = pb[w];
        if (!(py[f] > py[s]))
        begin
            t = f; f = s; s = t;
        end
        seg_pts[i].xl = px[f]; seg_pts[i].yl = py[f];
        seg_pts[i].xh = px[s]; seg_pts[i].yh = py[s];
        fit_line(i);
        return 1;
    endfunction

    function automatic void merge_round();
        int k;
        k = 0;
        for (int i = 0; i + 1 < seg_count; i++)
        begin
            if (absorbed[i]) continue;
            for (int j = i + 1; j < seg_count; j++)
                if (!absorbed[j] && try_join(i, j))
                    absorbed[j] = 1;
        end
        for (int i = 0; i < seg_count; i++)
        begin
            if (absorbed[i]) continue;
            seg_pts[k] = seg_pts[i];
            seg_slope[k] = seg_slope[i];
            seg_icpt[k] = seg_icpt[i];
            k++;
        end
        seg_count = k;
        absorbed = '{default: 0};
    endfunction

    // Works out the survivors that one accepted segment causes, if any.
    function automatic void predict_segment(in_item_t it);
        longint xa, ya, xb, yb, t;
        pts_t tp;
        out_item_t r;
        if (seg_count < MAX_SEGMENTS)
        begin
            xa = it.seg_x_a; ya = it.seg_y_a; xb = it.seg_x_b; yb = it.seg_y_b;
            if (ya < yb)
            begin
                t = xa; xa = xb; xb = t;
                t = ya; ya = yb; yb = t;
            end
            seg_pts[seg_count].xl = add_offset(xa, x_off);
            seg_pts[seg_count].yl = add_offset(ya, y_off);
            seg_pts[seg_count].xh = add_offset(xb, x_off);
            seg_pts[seg_count].yh = add_offset(yb, y_off);
            fit_line(seg_count);
            absorbed[seg_count] = 0;
            seg_count++;
        end
        else
            dropped_any = 1;
        if (!it.last_segment) return;
        for (int i = 0; i < seg_count; i++)
            for (int j = i + 1; j < seg_count; j++)
                if (seg_slope[i] > seg_slope[j])
                begin
                    tp = seg_pts[i]; seg_pts[i] = seg_pts[j]; seg_pts[j] = tp;
                    t = seg_slope[i]; seg_slope[i] = seg_slope[j]; seg_slope[j] = t;
                    t = seg_icpt[i]; seg_icpt[i] = seg_icpt[j]; seg_icpt[j] = t;
                end
        absorbed = '{default: 0};
        merge_round();
        merge_round();
        for (int i = 0; i < seg_count; i++)
        begin
            r.out_x_low = seg_pts[i].xl;
            r.out_y_low = seg_pts[i].yl;
            r.out_x_high = seg_pts[i].xh;
            r.out_y_high = seg_pts[i].yh;
            r.out_slope = seg_slope[i][23:0];
            r.out_intercept = seg_icpt[i][31:0];
            r.run_last = (i + 1 == seg_count);
            r.overflow_seen = dropped_any;
            expected_segments.push_back(r);
        end
        seg_count = 0;
        dropped_any = 0;
        absorbed = '{default: 0};
    endfunction

    function automatic in_item_t make_seg(int xa, int ya, int xb, int yb, bit last);
        in_item_t it;
        it.seg_x_a = (xa < 0) ? 10'd0 : (xa > 1023) ? 10'd1023 : xa[9:0];
        it.seg_y_a = (ya < 0) ? 10'd0 : (ya > 1023) ? 10'd1023 : ya[9:0];
        it.seg_x_b = (xb < 0) ? 10'd0 : (xb > 1023) ? 10'd1023 : xb[9:0];
        it.seg_y_b = (yb < 0) ? 10'd0 : (yb > 1023) ? 10'd1023 : yb[9:0];
        it.last_segment = last;
        return it;
    endfunction

    // Result checker: the receiver side decides its stall at the falling edge.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall = 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
        end
        else
            out_stall = ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_segments.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end
            else
            begin
                exp_r = expected_segments.pop_front();
                if (out_data.out_x_low !== exp_r.out_x_low
                    || out_data.out_y_low !== exp_r.out_y_low
                    || out_data.out_x_high !== exp_r.out_x_high
                    || out_data.out_y_high !== exp_r.out_y_high
                    || out_data.out_slope !== exp_r.out_slope
                    || out_data.out_intercept !== exp_r.out_intercept
                    || out_data.run_last !== exp_r.run_last
                    || out_data.overflow_seen !== exp_r.overflow_seen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_segment(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = it;
        do @(posedge clk); while (in_stall);
        predict_segment(it);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_segments.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_DATA_W-1:0];
        case (idx)
            CFG_SLOPE_THR: slope_thr = value & 64'hFFFF;
            CFG_ICPT_THR:  icpt_thr = value & 64'hFFFF;
            CFG_DIST_THR:  dist_thr = value & 64'h3FFFFF;
            CFG_X_OFF:     x_off = value & 1023;
            CFG_Y_OFF:     y_off = value & 1023;
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic write_all(longint st, longint it, longint dt, longint xo, longint yo);
        wait_idle();
        write_reg(CFG_SLOPE_THR, st);
        write_reg(CFG_ICPT_THR, it);
        write_reg(CFG_DIST_THR, dt);
        write_reg(CFG_X_OFF, xo);
        write_reg(CFG_Y_OFF, yo);
    endtask

    // One set: mostly short collinear runs that should merge, plus noise.
    task automatic send_random_set(int n);
        int bx, by, dx, dy, k, x0, y0;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(99) < 70)
            begin
                bx = $urandom_range(100, 800);
                by = $urandom_range(50, 700);
                dx = $urandom_range(0, 80) - 40;
                dy = $urandom_range(0, 80) - 40;
                for (int c = 0; c < $urandom_range(2, 5) && k < n; c++)
                begin
                    x0 = bx + c * dx + $urandom_range(0, 4) - 2;
                    y0 = by + c * dy + $urandom_range(0, 4) - 2;
                    k++;
                    send_segment(make_seg(x0, y0, x0 + dx * 4 / 5, y0 + dy * 4 / 5,
                                          k == n));
                end
            end
            else
            begin
                k++;
                send_segment(make_seg($urandom_range(1023), $urandom_range(1023),
                                      $urandom_range(1023), $urandom_range(1023), k == n));
            end
        end
    endtask

    task automatic test_directed();
        write_all(51, 160, 5000, 10, 200);
        send_segment(make_seg(0, 0, 0, 0, 0));
        send_segment(make_seg(1023, 1023, 1023, 1023, 0));
        send_segment(make_seg(5, 10, 5, 300, 0));
        send_segment(make_seg(0, 500, 1023, 500, 0));
        send_segment(make_seg(100, 50, 400, 700, 0));
        send_segment(make_seg(300, 300, 350, 350, 0));
        send_segment(make_seg(352, 352, 400, 400, 0));
        send_segment(make_seg(410, 410, 460, 460, 0));
        send_segment(make_seg(1023, 0, 0, 1023, 0));
        send_segment(make_seg(200, 600, 260, 602, 1));
        send_segment(make_seg(700, 100, 10, 900, 1));
        send_segment(make_seg(50, 50, 90, 60, 0));
        send_segment(make_seg(90, 60, 50, 50, 1));
    endtask

    task automatic test_config_extremes();
        write_all(65535, 65535, 2097152, 0, 0);
        send_random_set(8);
        write_all(0, 0, 0, 1023, 1023);
        send_random_set(4);
        write_all(65535, 65535, 4194303, 1023, 0);
        send_random_set(6);
        write_all(0, 65535, 2097152, 0, 1023);
        send_random_set(6);
        write_all(128, 400, 20000, 10, 200);
    endtask

    task automatic test_random_phase(int snd, int rcv, int items);
        int sent, n;
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        sent = 0;
        while (sent < items)
        begin
            n = $urandom_range(1, 6);
            send_random_set(n);
            sent += n;
        end
        write_all($urandom_range(0, 400), $urandom_range(0, 2000),
                  $urandom_range(0, 60000), $urandom_range(0, 60), $urandom_range(0, 300));
    endtask

    task automatic test_overflow();
        for (int k = 0; k < MAX_SEGMENTS + 3; k++)
            send_segment(make_seg($urandom_range(1023), $urandom_range(1023),
                                  $urandom_range(1023), $urandom_range(1023),
                                  k == MAX_SEGMENTS + 2));
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 3000;
        send_random_set(6);
        send_random_set(6);
        // Let everything drain before the next set goes in.
        while (expected_segments.size() != 0)
            @(negedge clk);
        send_random_set(5);
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 0;
        mismatches = 0;
        cycle_count = 0;
        seg_count = 0;
        dropped_any = 0;
        absorbed = '{default: 0};
        slope_thr = 51; icpt_thr = 160; dist_thr = 5000; x_off = 10; y_off = 200;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_config_extremes();
        test_random_phase(9, 57, 12);
        test_random_phase(57, 9, 12);
        test_random_phase(0, 0, 10);
        test_overflow();
        test_backpressure();
        while (expected_segments.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
src/lsm_pkg.sv
src/lsm_fit.sv
src/lsm_pair.sv
src/line_segment_merger.sv
tb/line_segment_merger_test.sv
